/* design/ostt_pkg.sv */
// ----------------------------------------------------------------------------
// ostt_pkg
// Shared types and codes for the one-shot timer table.
// ----------------------------------------------------------------------------
package ostt_pkg;

    localparam int ID_W   = 32;
    localparam int KIND_W = 3;
    localparam int REQ_W  = 2;

    // Request codes
    localparam logic [REQ_W-1:0] REQ_SCHEDULE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CANCEL   = 2'd1;
    localparam logic [REQ_W-1:0] REQ_TICK     = 2'd2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_SCHEDULED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_FULL      = 3'd1;
    localparam logic [KIND_W-1:0] KIND_FOUND     = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FIRED     = 3'd4;
    localparam logic [KIND_W-1:0] KIND_NOTHING   = 3'd5;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic [31:0]      delay_ticks;
        logic [ID_W-1:0]  cancel_id;
    } req_t;

    typedef struct packed {
        logic [KIND_W-1:0] resp_kind;
        logic [ID_W-1:0]   timer_id;
        logic              last;
    } rsp_t;

    // Per-cell control: shift takes the right neighbor, load takes the bus
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CANCEL,
        ST_TICK,
        ST_FLUSH
    } state_t;

endpackage

/* design/ostt_cell.sv */
// ----------------------------------------------------------------------------
// ostt_cell
// One timer slot: cancel flag, id and due time; shifts left or loads the bus.
// ----------------------------------------------------------------------------
module ostt_cell #(
    parameter int TIME_WIDTH = 48
) (
    input  logic                      clk,
    input  ostt_pkg::cell_ctrl_t      ctrl,
    input  logic                      nbr_cancelled,
    input  logic [ostt_pkg::ID_W-1:0] nbr_id,
    input  logic [TIME_WIDTH-1:0]     nbr_due,
    input  logic                      bus_cancelled,
    input  logic [ostt_pkg::ID_W-1:0] bus_id,
    input  logic [TIME_WIDTH-1:0]     bus_due,
    output logic                      cancelled,
    output logic [ostt_pkg::ID_W-1:0] id,
    output logic [TIME_WIDTH-1:0]     due
);
    import ostt_pkg::*;

    logic                  cancelled_reg, cancelled_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [TIME_WIDTH-1:0] due_reg, due_next;

    // Load wins over shift; otherwise hold
    always_comb
    begin
        cancelled_next = cancelled_reg;
        id_next        = id_reg;
        due_next       = due_reg;
        if (ctrl.load)
        begin
            cancelled_next = bus_cancelled;
            id_next        = bus_id;
            due_next       = bus_due;
        end
        else if (ctrl.shift)
        begin
            cancelled_next = nbr_cancelled;
            id_next        = nbr_id;
            due_next       = nbr_due;
        end
    end

    always_ff @(posedge clk)
    begin
        cancelled_reg <= cancelled_next;
        id_reg        <= id_next;
        due_reg       <= due_next;
    end

    assign cancelled = cancelled_reg;
    assign id        = id_reg;
    assign due       = due_reg;

endmodule

/* design/one_shot_timer_table.sv */
// ----------------------------------------------------------------------------
// one_shot_timer_table
// Table of pending one-shot timers held in a row of slot cells.
//
// channel   | signals           | handshake
// ----------+-------------------+---------------------------------------------
// request   | start, req        | taken when start is high and busy is low
// result    | done, rsp         | single-cycle items marked by done, no stall
//
// Pending timers sit packed in scheduling order in cells 0..count-1. Cancel and
// tick pass every pending entry once through cell 0: each cycle the row shifts
// left by one and the head, if kept, is written back behind the others.
// Schedule: result in the next cycle.
// Cancel: scans the N pending entries, result at the end (NOT_FOUND if none).
// Tick: scans each entry, then ST_FLUSH; fired ids stream out, last one flagged.
// The head compare in cell 0 (id or due time) sets the one-entry-per-cycle pace.
// Reset clears time, id counter, count and control; cell contents are don't care.
// ----------------------------------------------------------------------------
module one_shot_timer_table #(
    parameter int TABLE_DEPTH = 16,
    parameter int TIME_WIDTH  = 48
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  ostt_pkg::req_t req,
    output logic           busy,
    output logic           done,
    output ostt_pkg::rsp_t rsp
);
    import ostt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    // Control and state registers
    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      remain_reg, remain_next;
    logic [TIME_WIDTH-1:0] now_reg, now_next;
    logic [ID_W-1:0]       id_reg, id_next;
    logic [ID_W-1:0]       cid_reg, cid_next;
    logic                  found_reg, found_next;
    logic [ID_W-1:0]       pend_reg, pend_next;
    logic                  pendv_reg, pendv_next;
    logic                  done_reg, done_next;
    rsp_t                  rsp_reg, rsp_next;

    // Cell row
    logic                  cell_cancelled [TABLE_DEPTH];
    logic [ID_W-1:0]       cell_id        [TABLE_DEPTH];
    logic [TIME_WIDTH-1:0] cell_due       [TABLE_DEPTH];
    cell_ctrl_t            cell_ctrl      [TABLE_DEPTH];

    // Shared load bus
    logic                  shift_all;
    logic                  load_en;
    logic [CNT_W-1:0]      load_pos;
    logic [IDX_W-1:0]      load_idx;
    logic                  bus_cancelled;
    logic [ID_W-1:0]       bus_id;
    logic [TIME_WIDTH-1:0] bus_due;

    // Head evaluation and helpers
    logic                  accept;
    logic                  head_match;
    logic                  head_fire;
    logic [ID_W-1:0]       id_inc;
    logic [TIME_WIDTH:0]   due_sum;
    logic [TIME_WIDTH-1:0] due_sat;

    assign accept     = start && (state_reg == ST_IDLE);
    assign busy       = (state_reg != ST_IDLE);
    assign head_match = (cell_id[0] == cid_reg) && !found_reg;
    assign head_fire  = !cell_cancelled[0] && (now_reg >= cell_due[0]);

    // Next id skips zero on wrap
    assign id_inc = ((id_reg + ID_W'(1)) == '0) ? ID_W'(1) : (id_reg + ID_W'(1));

    // Due time saturates at the top of the time range
    assign due_sum = {1'b0, now_reg} + {{(TIME_WIDTH + 1 - 32){1'b0}}, req.delay_ticks};
    assign due_sat = due_sum[TIME_WIDTH] ? {TIME_WIDTH{1'b1}} : due_sum[TIME_WIDTH-1:0];

    assign load_idx = load_pos[IDX_W-1:0];

    genvar g;
    generate
        for (g = 0; g < TABLE_DEPTH; g++)
        begin : g_cell
            logic                  nbr_cancelled;
            logic [ID_W-1:0]       nbr_id;
            logic [TIME_WIDTH-1:0] nbr_due;

            if (g == TABLE_DEPTH - 1)
            begin : g_tail
                assign nbr_cancelled = 1'b0;
                assign nbr_id        = '0;
                assign nbr_due       = '0;
            end
            else
            begin : g_body
                assign nbr_cancelled = cell_cancelled[g+1];
                assign nbr_id        = cell_id[g+1];
                assign nbr_due       = cell_due[g+1];
            end

            assign cell_ctrl[g].shift = shift_all;
            assign cell_ctrl[g].load  = load_en && (load_idx == IDX_W'(g));

            ostt_cell #(
                .TIME_WIDTH (TIME_WIDTH)
            ) u_cell (
                .clk           (clk),
                .ctrl          (cell_ctrl[g]),
                .nbr_cancelled (nbr_cancelled),
                .nbr_id        (nbr_id),
                .nbr_due       (nbr_due),
                .bus_cancelled (bus_cancelled),
                .bus_id        (bus_id),
                .bus_due       (bus_due),
                .cancelled     (cell_cancelled[g]),
                .id            (cell_id[g]),
                .due           (cell_due[g])
            );
        end
    endgenerate

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (count_reg != '0))
                begin
                    if (req.req_type == REQ_CANCEL)
                        state_next = ST_CANCEL;
                    else if (req.req_type == REQ_TICK)
                        state_next = ST_TICK;
                end
            end
            ST_CANCEL:
            begin
                if (remain_reg == CNT_W'(1))
                    state_next = ST_IDLE;
            end
            ST_TICK:
            begin
                if (remain_reg == CNT_W'(1))
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        shift_all     = 1'b0;
        load_en       = 1'b0;
        load_pos      = count_reg;
        bus_cancelled = 1'b0;
        bus_id        = id_inc;
        bus_due       = due_sat;
        count_next    = count_reg;
        remain_next   = remain_reg;
        now_next      = now_reg;
        id_next       = id_reg;
        cid_next      = cid_reg;
        found_next    = found_reg;
        pend_next     = pend_reg;
        pendv_next    = pendv_reg;
        done_next     = 1'b0;
        rsp_next      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.req_type)
                        REQ_SCHEDULE:
                        begin
                            done_next     = 1'b1;
                            rsp_next.last = 1'b1;
                            if (count_reg == CNT_W'(TABLE_DEPTH))
                            begin
                                rsp_next.resp_kind = KIND_FULL;
                            end
                            else
                            begin
                                // Append at the tail
                                load_en            = 1'b1;
                                id_next            = id_inc;
                                count_next         = count_reg + CNT_W'(1);
                                rsp_next.resp_kind = KIND_SCHEDULED;
                                rsp_next.timer_id  = id_inc;
                            end
                        end
                        REQ_CANCEL:
                        begin
                            cid_next    = req.cancel_id;
                            found_next  = 1'b0;
                            remain_next = count_reg;
                            if (count_reg == '0)
                            begin
                                done_next          = 1'b1;
                                rsp_next.resp_kind = KIND_NOT_FOUND;
                                rsp_next.last      = 1'b1;
                            end
                        end
                        REQ_TICK:
                        begin
                            now_next    = now_reg + TIME_WIDTH'(1);
                            pendv_next  = 1'b0;
                            remain_next = count_reg;
                            if (count_reg == '0)
                            begin
                                done_next          = 1'b1;
                                rsp_next.resp_kind = KIND_NOTHING;
                                rsp_next.last      = 1'b1;
                            end
                        end
                        default:
                        begin
                            done_next = 1'b0;
                        end
                    endcase
                end
            end
            ST_CANCEL:
            begin
                // Rotate the head to the tail, marking the first match
                shift_all     = 1'b1;
                load_en       = 1'b1;
                load_pos      = count_reg - CNT_W'(1);
                bus_cancelled = cell_cancelled[0] || head_match;
                bus_id        = cell_id[0];
                bus_due       = cell_due[0];
                found_next    = found_reg || head_match;
                remain_next   = remain_reg - CNT_W'(1);
                if (remain_reg == CNT_W'(1))
                begin
                    done_next     = 1'b1;
                    rsp_next.last = 1'b1;
                    if (found_next)
                    begin
                        rsp_next.resp_kind = KIND_FOUND;
                        rsp_next.timer_id  = cid_reg;
                    end
                    else
                    begin
                        rsp_next.resp_kind = KIND_NOT_FOUND;
                    end
                end
            end
            ST_TICK:
            begin
                shift_all     = 1'b1;
                load_pos      = count_reg - CNT_W'(1);
                bus_cancelled = 1'b0;
                bus_id        = cell_id[0];
                bus_due       = cell_due[0];
                remain_next   = remain_reg - CNT_W'(1);
                if (!cell_cancelled[0] && !head_fire)
                    load_en = 1'b1;
                else
                    count_next = count_reg - CNT_W'(1);   // drop the head
                if (head_fire)
                begin
                    // Hold this id back until we know whether it is the last
                    if (pendv_reg)
                    begin
                        done_next          = 1'b1;
                        rsp_next.resp_kind = KIND_FIRED;
                        rsp_next.timer_id  = pend_reg;
                    end
                    pend_next  = cell_id[0];
                    pendv_next = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                done_next     = 1'b1;
                rsp_next.last = 1'b1;
                if (pendv_reg)
                begin
                    rsp_next.resp_kind = KIND_FIRED;
                    rsp_next.timer_id  = pend_reg;
                end
                else
                begin
                    rsp_next.resp_kind = KIND_NOTHING;
                end
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            remain_reg <= '0;
            now_reg    <= '0;
            id_reg     <= '0;
            found_reg  <= 1'b0;
            pendv_reg  <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            now_reg    <= now_next;
            id_reg     <= id_next;
            found_reg  <= found_next;
            pendv_reg  <= pendv_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cid_reg  <= cid_next;
        pend_reg <= pend_next;
        rsp_reg  <= rsp_next;
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

    // Fill count never passes the table size
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
        else $error("fill count above table depth");

    // Entries still to visit always lie within the pending entries
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TICK || state_reg == ST_CANCEL)
            |-> (remain_reg != '0) && (remain_reg <= count_reg))
        else $error("scan counter out of range");

    // A result that is not the last one only comes while the block is still busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !rsp.last) |-> busy)
        else $error("non-final result while idle");

    // A schedule into a table with room answers with a fresh id
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && req.req_type == REQ_SCHEDULE && count_reg != CNT_W'(TABLE_DEPTH))
            |=> done && (rsp.resp_kind == KIND_SCHEDULED) && (rsp.timer_id != '0)
                && (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("schedule did not append");

endmodule
